// ===== design/kwp_pkg.sv =====
// Package for the KWP2000 response deframer.
// Item types, code constants and sizing shared by the design modules; no dependencies.
package kwp_pkg;

   localparam int MAX_FRAME = 260;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic CSR_HEADER_LENGTH = 1'b0;
   localparam logic CSR_TIMEOUT_TICKS = 1'b1;

   localparam logic [2:0]  HEADER_LENGTH_RST = 3'd3;
   localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd1000;

   localparam logic [7:0] NEG_SID      = 8'h7f;
   localparam logic [7:0] PENDING_CODE = 8'h78;
   localparam logic [7:0] FMT_LEN_MASK = 8'h3f;

   typedef enum logic [1:0] {
      ST_POSITIVE,
      ST_NEGATIVE,
      ST_PENDING,
      ST_TIMEOUT
   } status_type;

   typedef enum logic [1:0] {
      PART_HEADER,
      PART_PAYLOAD,
      PART_CHECKSUM
   } part_type;

   typedef struct packed {
      logic       we;
      logic       index;
      logic [15:0] wdata;
   } csr_write_type;

   typedef struct packed {
      logic       op;
      logic [7:0] rx_byte;
   } req_item_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic [8:0] byte_index;
      part_type   part;
      logic       frame_end;
      status_type status;
      logic [7:0] service_id;
      logic [7:0] neg_service;
      logic [7:0] neg_code;
      logic [7:0] payload_length;
   } rsp_item_type;

endpackage

// ===== design/kwp_req_if.sv =====
// Input channel of the deframer: received byte or time tick.
// Valid/ready handshake; no dependencies.
interface kwp_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] rx_byte;

   modport source (output valid, op, rx_byte, input ready);
   modport sink (input valid, op, rx_byte, output ready);
endinterface

// ===== design/kwp_rsp_if.sv =====
// Result channel of the deframer: one item per byte, or a timeout.
// Valid/ready handshake; no dependencies.
interface kwp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic [8:0] byte_index;
   logic [1:0] part;
   logic       frame_end;
   logic [1:0] status;
   logic [7:0] service_id;
   logic [7:0] neg_service;
   logic [7:0] neg_code;
   logic [7:0] payload_length;

   modport source (output valid, data_byte, byte_index, part, frame_end, status,
                   service_id, neg_service, neg_code, payload_length, input ready);
   modport sink (input valid, data_byte, byte_index, part, frame_end, status,
                 service_id, neg_service, neg_code, payload_length, output ready);
endinterface

// ===== design/kwp_in_stage.sv =====
// Input register of the deframer: holds one accepted item until it is processed.
// Depends on kwp_pkg.
module kwp_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  kwp_pkg::req_item_type load_item,
   input  logic                  advance,
   output logic                  item_valid,
   output kwp_pkg::req_item_type item
);
   import kwp_pkg::*;

   logic         valid_ff, valid_in;
   req_item_type item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= load_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;
endmodule

// ===== design/kwp_frame_tracker.sv =====
// Frame state of the deframer: position, decoded length, first payload bytes,
// tick count and the two settings. Depends on kwp_pkg.
module kwp_frame_tracker (
   input  logic                   clock,
   input  logic                   reset,
   input  kwp_pkg::csr_write_type csr,
   input  logic                   fire,
   input  kwp_pkg::req_item_type  item,
   output logic                   result_valid,
   output kwp_pkg::rsp_item_type  result
);
   import kwp_pkg::*;

   logic [2:0]  header_length_ff, header_length_in;
   logic [15:0] timeout_ff, timeout_in;
   logic [8:0]  pos_ff, pos_in;
   logic [8:0]  flen_ff, flen_in;
   logic [7:0]  fp_ff [3];
   logic [7:0]  fp_in [3];
   logic [7:0]  fmt_ff, fmt_in;
   logic [15:0] elapsed_ff, elapsed_in;

   always_comb begin
      header_length_in = header_length_ff;
      timeout_in       = timeout_ff;
      if (csr.we) begin
         unique case (csr.index)
            CSR_HEADER_LENGTH: header_length_in = csr.wdata[2:0];
            CSR_TIMEOUT_TICKS: timeout_in = csr.wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      logic [2:0]  hl;
      logic [9:0]  pos_next;
      logic [8:0]  k;
      logic        in_payload;
      logic [7:0]  pl;
      logic [8:0]  end_len;
      logic [8:0]  flen_eff;
      logic        fend;
      logic        timeout;
      rsp_item_type r;

      hl = header_length_ff;
      if (header_length_ff == 3'd0) begin
         hl = 3'd1;
      end else if (header_length_ff > 3'd4) begin
         hl = 3'd4;
      end

      pos_next   = {1'b0, pos_ff} + 10'd1;
      in_payload = pos_ff >= {6'd0, hl};
      k          = pos_ff - {6'd0, hl};
      timeout    = elapsed_ff >= timeout_ff;

      pos_in     = pos_ff;
      flen_in    = flen_ff;
      fmt_in     = fmt_ff;
      fp_in      = fp_ff;
      elapsed_in = elapsed_ff;
      fend       = 1'b0;
      pl         = 8'd0;
      end_len    = flen_ff;
      flen_eff   = flen_ff;

      r                = '0;
      r.data_byte      = item.rx_byte;
      r.byte_index     = pos_ff;
      r.part           = in_payload ? PART_PAYLOAD : PART_HEADER;
      r.status         = ST_POSITIVE;
      result_valid     = 1'b0;

      if (item.op == OP_TICK) begin
         r            = '0;
         r.byte_index = pos_ff;
         r.part       = PART_HEADER;
         r.status     = ST_POSITIVE;
         if (timeout) begin
            result_valid = 1'b1;
            r.frame_end  = 1'b1;
            r.status     = ST_TIMEOUT;
         end
      end else begin
         result_valid = 1'b1;
         if (pos_ff == 9'd0) begin
            fmt_in = item.rx_byte;
         end
         for (int i = 0; i < 3; i++) begin
            if (in_payload && k == 9'(i)) begin
               fp_in[i] = item.rx_byte;
            end
         end

         if (flen_ff == 9'd0) begin
            if (pos_next >= {7'd0, hl}) begin
               // odd header: length in the format byte, else the last header byte
               pl       = hl[0] ? (fmt_in & FMT_LEN_MASK) : item.rx_byte;
               flen_eff = {1'b0, pl} + {6'd0, hl} + 9'd1;
               flen_in  = flen_eff;
            end
         end else begin
            if (flen_ff > 9'(MAX_FRAME)) begin
               end_len = 9'(MAX_FRAME);
            end
            if (pos_next >= {1'b0, end_len}) begin
               fend   = 1'b1;
               r.part = PART_CHECKSUM;
            end
         end

         if (flen_eff != 9'd0) begin
            r.payload_length = 8'(flen_eff - {6'd0, hl} - 9'd1);
         end

         r.frame_end = fend;
         if (fend) begin
            r.service_id = fp_in[0];
            priority if (fp_in[0] == NEG_SID && fp_in[2] == PENDING_CODE) begin
               r.status = ST_PENDING;
            end else if (fp_in[0] == NEG_SID) begin
               r.status      = ST_NEGATIVE;
               r.neg_service = fp_in[1];
               r.neg_code    = fp_in[2];
            end else begin
               r.status = ST_POSITIVE;
            end
         end
      end

      if (fire) begin
         if (item.op == OP_TICK) begin
            if (timeout) begin
               pos_in     = '0;
               flen_in    = '0;
               fmt_in     = '0;
               fp_in      = '{default: '0};
               elapsed_in = '0;
            end else begin
               elapsed_in = elapsed_ff + 16'd1;
            end
         end else if (fend) begin
            pos_in  = '0;
            flen_in = '0;
            fmt_in  = '0;
            fp_in   = '{default: '0};
            // a pending frame keeps the wait running
            if (r.status != ST_PENDING) begin
               elapsed_in = '0;
            end
         end else begin
            pos_in = pos_next[8:0];
         end
      end else begin
         flen_in = flen_ff;
         fmt_in  = fmt_ff;
         fp_in   = fp_ff;
      end

      result = r;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_length_ff <= HEADER_LENGTH_RST;
         timeout_ff       <= TIMEOUT_TICKS_RST;
         pos_ff           <= '0;
         flen_ff          <= '0;
         fmt_ff           <= '0;
         fp_ff            <= '{default: '0};
         elapsed_ff       <= '0;
      end else begin
         header_length_ff <= header_length_in;
         timeout_ff       <= timeout_in;
         pos_ff           <= pos_in;
         flen_ff          <= flen_in;
         fmt_ff           <= fmt_in;
         fp_ff            <= fp_in;
         elapsed_ff       <= elapsed_in;
      end
   end
endmodule

// ===== design/kwp_out_stage.sv =====
// Result register of the deframer: holds one result item until the sink takes it.
// Depends on kwp_pkg.
module kwp_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  kwp_pkg::rsp_item_type load_item,
   input  logic                  out_ready,
   output logic                  can_accept,
   output logic                  out_valid,
   output kwp_pkg::rsp_item_type out_item
);
   import kwp_pkg::*;

   logic         valid_ff, valid_in;
   rsp_item_type item_ff;

   assign can_accept = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= load_item;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;
endmodule

// ===== design/kwp2000_response_deframer.sv =====
// KWP2000 response deframer: places received bytes in ISO14230 frames and reports frame results.
// Items pass the input register, then the result register; a full result register stalls them.
// Throughput: one item per cycle unless the sink stalls; a tick without timeout gives no result.
// Reset (synchronous): settings back to header length 3 and 1000 ticks, frame state cleared.
// Depends on kwp_pkg, kwp_req_if, kwp_rsp_if, kwp_in_stage, kwp_frame_tracker, kwp_out_stage.
module kwp2000_response_deframer (
   input  logic        clock,
   input  logic        reset,
   kwp_req_if.sink     req_ch,
   kwp_rsp_if.source   rsp_ch,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);
   import kwp_pkg::*;

   csr_write_type csr;
   req_item_type  req_item;
   req_item_type  s1_item;
   logic          s1_valid;
   logic          advance;
   logic          accept;
   logic          can_accept;
   logic          result_valid;
   rsp_item_type  result;
   rsp_item_type  out_item;

   assign csr.we    = csr_we;
   assign csr.index = csr_index;
   assign csr.wdata = csr_wdata;

   assign req_item.op      = req_ch.op;
   assign req_item.rx_byte = req_ch.rx_byte;

   assign advance      = s1_valid && can_accept;
   assign req_ch.ready = !s1_valid || can_accept;
   assign accept       = req_ch.valid && req_ch.ready;

   kwp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .load_item  (req_item),
      .advance    (advance),
      .item_valid (s1_valid),
      .item       (s1_item)
   );

   kwp_frame_tracker u_tracker (
      .clock        (clock),
      .reset        (reset),
      .csr          (csr),
      .fire         (advance),
      .item         (s1_item),
      .result_valid (result_valid),
      .result       (result)
   );

   kwp_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (advance && result_valid),
      .load_item  (result),
      .out_ready  (rsp_ch.ready),
      .can_accept (can_accept),
      .out_valid  (rsp_ch.valid),
      .out_item   (out_item)
   );

   assign rsp_ch.data_byte      = out_item.data_byte;
   assign rsp_ch.byte_index     = out_item.byte_index;
   assign rsp_ch.part           = out_item.part;
   assign rsp_ch.frame_end      = out_item.frame_end;
   assign rsp_ch.status         = out_item.status;
   assign rsp_ch.service_id     = out_item.service_id;
   assign rsp_ch.neg_service    = out_item.neg_service;
   assign rsp_ch.neg_code       = out_item.neg_code;
   assign rsp_ch.payload_length = out_item.payload_length;

`ifndef SYNTH
   a_end_is_checksum: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.frame_end && rsp_ch.status != ST_TIMEOUT
      |-> rsp_ch.part == PART_CHECKSUM)
      else $error("frame end on a byte that is not the checksum");

   a_midframe_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.frame_end
      |-> rsp_ch.status == ST_POSITIVE && rsp_ch.service_id == 8'd0)
      else $error("status or service set on a mid-frame item");

   a_neg_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.status != ST_NEGATIVE
      |-> rsp_ch.neg_service == 8'd0 && rsp_ch.neg_code == 8'd0)
      else $error("negative fields set on a non-negative item");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> rsp_ch.byte_index < 9'(MAX_FRAME))
      else $error("byte index beyond the largest frame");
`endif
endmodule
